### design/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set table: request kinds,
// status codes, field widths, controller states and the cell control word.
// ----------------------------------------------------------------------------
package sus_pkg;

   // fixed field widths of the request and response words
   localparam int KIND_W   = 2;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd4;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic capture;   // latch compare and select flags for a new word
      logic insert;    // shift right from the insert point and place the key
   } cell_ctrl_type;

endpackage

### design/sorted_unique_set_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_table
// Bounded set of unsigned values kept in ascending order without duplicates,
// held in a chain of compare cells. Insert, lookup, remove largest and read
// at sorted position, one response word per request word.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  req_kind, req_value, req_index
//  rsp       out        rsp_valid / rsp_stall  rsp_status, rsp_found,
//                                              rsp_read_value, rsp_count
//
//  a request is accepted in idle, where every cell latches its compare flags;
//  the commit then shifts the chain, updates the count and loads the
//  response register, and the next request is taken back in idle
//  a stalled response holds the commit until the response register frees
//  reset clears the count, controller state and response valid; entries
//  need no clearing since only slots below the count are ever read
// ----------------------------------------------------------------------------
module sorted_unique_set_table #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sus_pkg::KIND_W-1:0]    req_kind,
   input  logic [sus_pkg::DATA_W-1:0]    req_value,
   input  logic [sus_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sus_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [sus_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [sus_pkg::COUNT_W-1:0]   rsp_count
);
   import sus_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  found_ff, found_in;
   logic [DATA_W-1:0]     read_ff, read_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  accept;
   logic                  out_free;
   logic                  commit;
   logic [63:0]           value_wide;
   logic [VALUE_BITS-1:0] key_in;
   cell_ctrl_type         ctrl;

   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic [VALUE_BITS-1:0] cell_read  [CAPACITY];
   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic                  hit;
   logic                  full;
   logic                  in_range;
   logic [VALUE_BITS-1:0] read_or;
   logic [63:0]           read_wide;

   // key keeps only the low VALUE_BITS bits of the request value
   assign value_wide = 64'(req_value);
   assign key_in     = value_wide[VALUE_BITS-1:0];

   // handshake qualifiers
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // controller next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid)  state_in = ST_COMMIT;
         ST_COMMIT: if (out_free)   state_in = ST_IDLE;
         default:                   state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_COMMIT: commit    = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request word held for the commit cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         key_ff   <= key_in;
         index_ff <= req_index;
      end
   end

   // global results reduced from the cell flags
   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_read[i];
      end
   end

   assign hit       = |eq_vec;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign in_range  = 32'(index_ff) < 32'(count_ff);
   assign read_wide = 64'(read_or);

   assign ctrl.capture = accept;
   assign ctrl.insert  = commit && (kind_ff == KIND_INSERT) && !hit && !full;

   // cell chain, each cell fed by its left neighbor
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic                  left_lt;

      if (g == 0) begin : g_head
         assign left_value = '0;
         assign left_lt    = 1'b1;
      end else begin : g_link
         assign left_value = cell_value[g-1];
         assign left_lt    = lt_vec[g-1];
      end

      sus_cell #(
         .VALUE_BITS (VALUE_BITS),
         .CNT_W      (CNT_W),
         .POSITION   (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key        (key_in),
         .new_value  (key_ff),
         .count      (count_ff),
         .index      (req_index),
         .left_value (left_value),
         .left_lt    (left_lt),
         .value      (cell_value[g]),
         .lt         (lt_vec[g]),
         .eq         (eq_vec[g]),
         .read_data  (cell_read[g])
      );
   end

   // response word and next count
   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      found_in  = 1'b0;
      read_in   = '0;
      case (kind_ff)
         KIND_INSERT: begin
            if (hit) begin
               status_in = STATUS_DUPLICATE;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_LOOKUP: begin
            found_in = hit;
         end
         KIND_REMOVE: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (in_range) begin
               read_in = read_wide[DATA_W-1:0];
            end else begin
               status_in = STATUS_RANGE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         read_ff      <= read_in;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = read_ff;
   assign rsp_count      = rsp_count_ff;

   // fill count never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("fill count above capacity");

   // a response appears only out of a commit cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("response without commit");

   // successful insert grows the set by one
   assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   // a held request is never overwritten while waiting to commit
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT && !out_free |=> state_ff == ST_COMMIT && $stable(key_ff))
      else $error("pending request lost");

   // found is only reported with an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && found_ff |-> status_ff == STATUS_OK)
      else $error("found with error status");

endmodule

### design/sus_cell.sv
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted chain. Holds one entry, compares it against the
// broadcast key and hands its entry and its less-than flag to the next cell.
// ----------------------------------------------------------------------------
module sus_cell #(
   parameter int VALUE_BITS = 32,
   parameter int CNT_W      = 7,
   parameter int POSITION   = 0
) (
   input  logic                         clock,
   input  sus_pkg::cell_ctrl_type       ctrl,
   input  logic [VALUE_BITS-1:0]        key,
   input  logic [VALUE_BITS-1:0]        new_value,
   input  logic [CNT_W-1:0]             count,
   input  logic [sus_pkg::INDEX_W-1:0]  index,
   input  logic [VALUE_BITS-1:0]        left_value,
   input  logic                         left_lt,
   output logic [VALUE_BITS-1:0]        value,
   output logic                         lt,
   output logic                         eq,
   output logic [VALUE_BITS-1:0]        read_data
);
   import sus_pkg::*;

   logic [VALUE_BITS-1:0] value_ff;
   logic                  lt_ff;
   logic                  eq_ff;
   logic                  sel_ff;
   logic                  occupied;

   // slot holds a live entry when it lies below the fill count
   assign occupied = 32'(count) > POSITION;

   // compare flags, taken when a word is accepted
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         lt_ff  <= occupied && (value_ff < key);
         eq_ff  <= occupied && (value_ff == key);
         sel_ff <= 32'(index) == POSITION;
      end
   end

   // entries at or above the insert point move one slot to the right, and the new key takes the insert point
   always_ff @(posedge clock) begin
      if (ctrl.insert && !lt_ff) begin
         value_ff <= left_lt ? new_value : left_value;
      end
   end

   assign value     = value_ff;
   assign lt        = lt_ff;
   assign eq        = eq_ff;
   assign read_data = sel_ff ? value_ff : '0;

endmodule

### sim/tb_sorted_unique_set_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_unique_set_table
// Self-checking bench for the sorted unique set table. A short table of
// directed words covers empty, range, duplicate and extreme values. Random
// phases follow that fill, drain, mix and query the set. Every accepted
// response word is compared field by field against a behavioral copy of the
// set or a typed directed expectation, with random gaps on the request side
// and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_sorted_unique_set_table;
   timeunit 1ns;
   timeprecision 1ps;

   import sus_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PLAN_LEN     = 25;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [DATA_W-1:0]   read_value;
      logic [COUNT_W-1:0]  count;
   } rsp_word_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      bit                 typed;
      rsp_word_type       want;
   } plan_row_type;

   typedef enum {
      FLAVOR_FILL,
      FLAVOR_DRAIN,
      FLAVOR_BALANCED,
      FLAVOR_QUERY
   } flavor_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind  = KIND_LOOKUP;
   logic [DATA_W-1:0]    req_value = '0;
   logic [INDEX_W-1:0]   req_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_found;
   logic [DATA_W-1:0]    rsp_read_value;
   logic [COUNT_W-1:0]   rsp_count;

   // shadow copy of the set and the words still owed by the block
   logic [DATA_W-1:0] set_vals [CAPACITY];
   int                set_size = 0;
   rsp_word_type      pending_rsp [$];
   int                errors = 0;
   int                cycles = 0;
   int                burst_left = 0;

   // directed words; typed expectations only where obvious
   plan_row_type plan [PLAN_LEN] = '{
      '{KIND_REMOVE, 32'h0000_0000, 6'd0,  1'b1, '{STATUS_EMPTY, 1'b0, 32'h0, 7'd0}},
      '{KIND_READ,   32'h0000_0000, 6'd0,  1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 7'd0}},
      '{KIND_READ,   32'hFFFF_FFFF, 6'd63, 1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 7'd0}},
      '{KIND_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, '{STATUS_OK, 1'b0, 32'h0, 7'd0}},
      '{KIND_INSERT, 32'h0000_0000, 6'd0,  1'b1, '{STATUS_OK, 1'b0, 32'h0, 7'd1}},
      '{KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b1, '{STATUS_OK, 1'b0, 32'h0, 7'd2}},
      '{KIND_INSERT, 32'h0000_0000, 6'd0,  1'b1, '{STATUS_DUPLICATE, 1'b0, 32'h0, 7'd2}},
      '{KIND_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, '{STATUS_DUPLICATE, 1'b0, 32'h0, 7'd2}},
      '{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, '{STATUS_OK, 1'b1, 32'h0, 7'd2}},
      '{KIND_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, '{STATUS_OK, 1'b1, 32'h0, 7'd2}},
      '{KIND_READ,   32'h0000_0000, 6'd0,  1'b1, '{STATUS_OK, 1'b0, 32'h0, 7'd2}},
      '{KIND_READ,   32'h0000_0000, 6'd1,  1'b1, '{STATUS_OK, 1'b0, 32'hFFFF_FFFF, 7'd2}},
      '{KIND_READ,   32'h0000_0000, 6'd2,  1'b1, '{STATUS_RANGE, 1'b0, 32'h0, 7'd2}},
      '{KIND_INSERT, 32'h8000_0000, 6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
      '{KIND_INSERT, 32'hAAAA_AAAA, 6'h2A, 1'b0, '0},
      '{KIND_INSERT, 32'h5555_5555, 6'h15, 1'b0, '0},
      '{KIND_READ,   32'h1234_5678, 6'd3,  1'b0, '0},
      '{KIND_LOOKUP, 32'h1234_5678, 6'd0,  1'b0, '0},
      '{KIND_LOOKUP, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
      '{KIND_REMOVE, 32'h0000_0000, 6'd0,  1'b0, '0},
      '{KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
      '{KIND_READ,   32'h0000_0000, 6'd63, 1'b0, '0},
      '{KIND_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
      '{KIND_READ,   32'h0000_0000, 6'd5,  1'b0, '0}
   };

   sorted_unique_set_table #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (DATA_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words outstanding", $time, pending_rsp.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // applies one request word to the shadow set and returns the response word
   function automatic rsp_word_type apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [DATA_W-1:0] value,
                                                  input logic [INDEX_W-1:0] index);
      rsp_word_type r;
      int           pos;
      int           i;
      bit           hit;
      r   = '0;
      pos = 0;
      // first slot not below the value; sorted, so a hit sits right there
      while (pos < set_size && set_vals[pos] < value)
         pos++;
      hit = (pos < set_size) && (set_vals[pos] == value);
      case (kind)
         KIND_INSERT: begin
            if (hit) begin
               r.status = STATUS_DUPLICATE;
            end else if (set_size >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = set_size; i > pos; i--)
                  set_vals[i] = set_vals[i-1];
               set_vals[pos] = value;
               set_size++;
            end
         end
         KIND_LOOKUP: begin
            r.found = hit;
         end
         KIND_REMOVE: begin
            if (set_size == 0)
               r.status = STATUS_EMPTY;
            else
               set_size--;
         end
         default: begin
            if (int'(index) < set_size)
               r.read_value = set_vals[index];
            else
               r.status = STATUS_RANGE;
         end
      endcase
      r.count = COUNT_W'(set_size);
      return r;
   endfunction

   // presents one word, holds it until taken, then books its response
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                            input logic [INDEX_W-1:0] index, input bit typed,
                            input rsp_word_type want);
      rsp_word_type predicted;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (req_stall);
      predicted = apply_request(kind, value, index);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   // sender bursts with random gaps, some bursts back to back
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // hold off until every booked response has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // value source: small pool and extremes for duplicates, live entries, or wide random
   function automatic logic [DATA_W-1:0] pick_value(input bit mostly_fresh);
      int sel;
      sel = $urandom_range(0, 9);
      if (mostly_fresh && sel < 7)
         return $urandom;
      if (sel < 3) begin
         case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return DATA_W'($urandom_range(0, 15));
         endcase
      end
      if (sel < 6 && set_size > 0)
         return set_vals[$urandom_range(0, set_size - 1)];
      return $urandom;
   endfunction

   // random words in phases that steer the set between empty and full
   task automatic run_random();
      flavor_type         flavor;
      int                 sent;
      int                 phase_len;
      int                 roll;
      int                 cut_insert;
      int                 cut_lookup;
      int                 cut_remove;
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      sent   = 0;
      flavor = FLAVOR_FILL;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(60, 160);
         // last phase stops at the word budget
         if (phase_len > RANDOM_ITEMS - sent)
            phase_len = RANDOM_ITEMS - sent;
         case (flavor)
            FLAVOR_FILL:     begin cut_insert = 75; cut_lookup = 85; cut_remove = 88; end
            FLAVOR_DRAIN:    begin cut_insert = 15; cut_lookup = 30; cut_remove = 80; end
            FLAVOR_BALANCED: begin cut_insert = 35; cut_lookup = 60; cut_remove = 75; end
            default:         begin cut_insert = 10; cut_lookup = 55; cut_remove = 60; end
         endcase
         repeat (phase_len) begin
            roll  = $urandom_range(0, 99);
            kind  = (roll < cut_insert) ? KIND_INSERT :
                    (roll < cut_lookup) ? KIND_LOOKUP :
                    (roll < cut_remove) ? KIND_REMOVE : KIND_READ;
            value = pick_value(flavor == FLAVOR_FILL);
            // reads mostly land on live slots, the rest anywhere
            if (set_size > 0 && $urandom_range(0, 9) < 7)
               index = INDEX_W'($urandom_range(0, set_size - 1));
            else
               index = INDEX_W'($urandom_range(0, 63));
            send_word(kind, value, index, 1'b0, '0);
            sent++;
            pace_sender();
         end
         if (sent < RANDOM_ITEMS && $urandom_range(0, 2) == 0)
            wait_quiet();
         flavor = flavor_type'($urandom_range(0, 3));
      end
   endtask

   // stimulus and end of run
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[n]) begin
         send_word(plan[n].kind, plan[n].value, plan[n].index, plan[n].typed, plan[n].want);
         pace_sender();
      end
      wait_quiet();
      run_random();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // receiver stall patterns: none, light, heavy, periodic, long runs
   initial begin
      int mode;
      int span;
      int run;
      forever begin
         mode = $urandom_range(0, 4);
         span = $urandom_range(20, 200);
         run  = 0;
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               3: rsp_stall <= (span % 3 == 0);
               default: begin
                  if (run == 0) begin
                     run = $urandom_range(1, 15);
                     rsp_stall <= ~rsp_stall;
                  end
                  run--;
               end
            endcase
            span--;
         end
      end
   end

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // response checker
   rsp_word_type want_rsp;
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response word with nothing outstanding, status %0h count %0d",
                     $time, rsp_status, rsp_count);
            errors++;
         end else begin
            want_rsp = pending_rsp.pop_front();
            check_field("status", DATA_W'(want_rsp.status), DATA_W'(rsp_status));
            check_field("found", DATA_W'(want_rsp.found), DATA_W'(rsp_found));
            check_field("read_value", want_rsp.read_value, rsp_read_value);
            check_field("count", DATA_W'(want_rsp.count), DATA_W'(rsp_count));
         end
      end
   end

endmodule

### filelist.f
design/sus_pkg.sv
design/sus_cell.sv
design/sorted_unique_set_table.sv
sim/tb_sorted_unique_set_table.sv
